// ----- hw/rtl/q7ce_pkg.sv -----
`timescale 1ns / 1ps

package q7ce_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int FRAC_BITS = 7;
  localparam int Q7_MAX    = 127;
  localparam int Q7_MIN    = -128;

  // Request kinds.
  localparam logic REQ_LOAD_A   = 1'b0;
  localparam logic REQ_STREAM_B = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    req_type;
    sample_t sample;
    logic    last;
  } req_t;

  typedef struct packed {
    sample_t value;
    logic    clamped;
    logic    taps_dropped;
    logic    final_res;
  } res_t;

  // Controls broadcast to every cell of the row.
  typedef struct packed {
    logic    shift;
    sample_t shift_val;
    sample_t tap_val;
    logic    clear;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/q7_convolution_engine_top.sv -----
`timescale 1ns / 1ps

// Streaming full linear convolution of two signed Q7 sequences. A request with
// req_type 0 appends one element of signal A to a row of MAX_TAPS cells; extra
// elements are dropped and reported through taps_dropped on every later
// result. A request with req_type 1 shifts one element of signal B into the
// history held along the same row and yields one result: the sum of
// tap times history over the row, arithmetically shifted right by 7 and
// saturated to -128..127 (clamped flags saturation). When a B request carries
// last, the block follows that result with tap count minus one tail results,
// as if zeros were fed in, marks the very last one with final_res, and then
// clears taps, history and the drop flag for the next pair. The block works
// on one request at a time and stalls new requests while a B request and any
// tail results it starts are being summed; each sum is formed by the partial
// sum rippling one cell per clock through the row of MAX_TAPS multiply-add
// cells. A finished result waits in an output register, so the next request
// can be taken while it is unread.
module q7_convolution_engine_top #(
  parameter int MAX_TAPS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  q7ce_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output q7ce_pkg::res_t  res
);
  import q7ce_pkg::*;

  // Sum width: each product fits 16 signed bits, MAX_TAPS of them add log2 bits.
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int QW    = ACC_W - FRAC_BITS;
  localparam logic signed [QW-1:0] Q_HI = QW'(Q7_MAX);
  localparam logic signed [QW-1:0] Q_LO = QW'(Q7_MIN);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                   state;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            tap_count;
  logic [CW-1:0]            tail_left;
  logic                     overflow_seen;
  logic                     draining;

  logic                     req_take;
  logic                     load_a;
  logic                     tap_wr;
  logic                     start_b;
  logic                     wave_done;
  logic                     res_free;
  logic                     emit;
  logic                     is_final;
  logic                     tail_step;
  cell_ctrl_t               ctrl;
  logic [MAX_TAPS-1:0]      tap_we;
  sample_t                  hist_q [MAX_TAPS];
  logic signed [ACC_W-1:0]  psum_q [MAX_TAPS];
  logic signed [ACC_W-1:0]  acc;
  logic signed [QW-1:0]     q;
  logic                     sat_hi;
  logic                     sat_lo;
  res_t                     res_next;

  // Requests are taken only while no result is being computed.
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign load_a    = req_take && (req.req_type == REQ_LOAD_A);
  assign tap_wr    = load_a && (tap_count < CW'(MAX_TAPS));
  assign start_b   = req_take && (req.req_type == REQ_STREAM_B);

  // Once the counter reaches MAX_TAPS with frozen history, the last cell holds the sum.
  assign wave_done = (state == ST_RUN) && (cnt == CW'(MAX_TAPS));
  assign res_free  = !res_valid || !res_stall;
  assign emit      = wave_done && res_free;
  assign is_final  = draining && (tail_left == '0);
  assign tail_step = emit && draining && (tail_left != '0);

  always_comb begin
    ctrl.shift     = start_b || tail_step;
    ctrl.shift_val = start_b ? req.sample : '0;
    ctrl.tap_val   = req.sample;
    ctrl.clear     = emit && is_final;
  end

  // The row of cells: history shifts toward higher indexes, the partial sum
  // ripples the same way and leaves from the last cell.
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [ACC_W-1:0] psum_in;
    sample_t                 hist_in;

    assign tap_we[j] = tap_wr && (tap_count == CW'(j));

    if (j == 0) begin : g_head
      assign psum_in = '0;
      assign hist_in = ctrl.shift_val;
    end else begin : g_body
      assign psum_in = psum_q[j-1];
      assign hist_in = hist_q[j-1];
    end

    q7ce_cell #(
      .ACC_W(ACC_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .tap_we   (tap_we[j]),
      .hist_in  (hist_in),
      .hist_out (hist_q[j]),
      .psum_in  (psum_in),
      .psum_out (psum_q[j])
    );
  end

  // Floor shift by the fraction bits, then saturate to the Q7 range.
  assign acc    = psum_q[MAX_TAPS-1];
  assign q      = QW'(acc >>> FRAC_BITS);
  assign sat_hi = (q > Q_HI);
  assign sat_lo = (q < Q_LO);

  always_comb begin
    if (sat_hi) begin
      res_next.value = SAMPLE_W'(Q7_MAX);
    end else if (sat_lo) begin
      res_next.value = SAMPLE_W'(Q7_MIN);
    end else begin
      res_next.value = q[SAMPLE_W-1:0];
    end
    res_next.clamped      = sat_hi || sat_lo;
    res_next.taps_dropped = overflow_seen;
    res_next.final_res    = is_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start_b) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit && !tail_step) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The wave counter restarts whenever new history enters the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start_b || tail_step) begin
      cnt <= '0;
    end else if ((state == ST_RUN) && !wave_done) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      tap_count     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (tap_wr) begin
        tap_count <= tap_count + 1'b1;
      end
      if (load_a && !tap_wr) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // A last B request leaves tap count minus one tail results to produce.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      tail_left <= '0;
    end else if (start_b) begin
      draining  <= req.last;
      tail_left <= (tap_count == '0) ? '0 : tap_count - 1'b1;
    end else if (tail_step) begin
      tail_left <= tail_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

  // The tap count can never run past the number of cells.
  a_tap_count_bound : assert property (@(posedge clk) disable iff (rst)
    tap_count <= CW'(MAX_TAPS))
    else $error("tap count exceeds the number of cells");

  // History must stay frozen while the partial sum ripples through the row; the check watches the first cell.
  a_hist_frozen : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && (cnt != '0) |-> $stable(hist_q[0]))
    else $error("history moved during a running sum");

  // The final result leaves the block empty and ready for the next pair.
  a_clear_after_final : assert property (@(posedge clk) disable iff (rst)
    emit && is_final |=> (state == ST_IDLE) && (tap_count == '0) && !overflow_seen)
    else $error("block not cleared after the final result");

endmodule

// ----- hw/rtl/q7ce_cell.sv -----
`timescale 1ns / 1ps

module q7ce_cell #(
  parameter int ACC_W = 21
) (
  input  logic                     clk,
  input  logic                     rst,
  input  q7ce_pkg::cell_ctrl_t     ctrl,
  input  logic                     tap_we,
  input  q7ce_pkg::sample_t        hist_in,
  output q7ce_pkg::sample_t        hist_out,
  input  logic signed [ACC_W-1:0]  psum_in,
  output logic signed [ACC_W-1:0]  psum_out
);
  import q7ce_pkg::*;

  sample_t                   tap;
  sample_t                   hist;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   psum;

  assign prod     = tap * hist;
  assign hist_out = hist;
  assign psum_out = psum;

  // One coefficient and one history sample live here; clearing empties both.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      tap  <= '0;
      hist <= '0;
    end else begin
      if (tap_we) begin
        tap <= ctrl.tap_val;
      end
      if (ctrl.shift) begin
        hist <= hist_in;
      end
    end
  end

  // The partial sum moves one cell further on every clock.
  always_ff @(posedge clk) begin
    psum <= psum_in + ACC_W'(prod);
  end

endmodule
